// ===== sv/ifcm_pkg.sv =====
// shared types, constants and register codes for the infrared false-colour map
package ifcm_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int GAIN_W       = 9;
    localparam int K_W          = 8;
    localparam int DOM_W        = CHANNEL_BITS + GAIN_W;
    localparam int PUSH_W       = DOM_W + K_W;
    localparam int PUSH_SHIFT   = 16;
    localparam int DIFF_W       = CHANNEL_BITS + 1;
    localparam int WEIGHT_W     = GAIN_W + 1;
    localparam int BLEND_W      = DIFF_W + WEIGHT_W + 1;
    localparam int BLEND_SHIFT  = 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic [GAIN_W-1:0] Q8_ONE = GAIN_W'(256);

    localparam logic [GAIN_W-1:0] RST_EFFECT_STRENGTH = GAIN_W'(205);
    localparam logic [GAIN_W-1:0] RST_FOLIAGE_GAIN    = GAIN_W'(205);
    localparam logic [GAIN_W-1:0] RST_SKY_GAIN        = GAIN_W'(128);
    localparam logic [GAIN_W-1:0] RST_OVERALL_MIX     = GAIN_W'(256);

    // q8 scale factors of the colour pushes
    localparam logic [K_W-1:0] K_MAG_RED    = K_W'(154);
    localparam logic [K_W-1:0] K_MAG_BLUE   = K_W'(128);
    localparam logic [K_W-1:0] K_MAG_GREEN  = K_W'(51);
    localparam logic [K_W-1:0] K_CYAN_GREEN = K_W'(128);
    localparam logic [K_W-1:0] K_CYAN_RED   = K_W'(77);

    localparam logic [PUSH_W-1:0]  PUSH_ROUND  = PUSH_W'(32768);
    localparam logic [BLEND_W-1:0] BLEND_ROUND = BLEND_W'(128);

    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [GAIN_W-1:0]       t_gain;
    typedef logic [DOM_W-1:0]        t_dom;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EFFECT_STRENGTH = 2'd0,
        CFG_FOLIAGE_GAIN    = 2'd1,
        CFG_SKY_GAIN        = 2'd2,
        CFG_OVERALL_MIX     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_pix_out;

    typedef struct packed {
        t_chan r;
        t_chan g;
        t_chan b;
    } t_rgb;

    typedef struct packed {
        t_gain strength;
        t_gain foliage;
        t_gain sky;
        t_gain mix;
    } t_gains;

    // source colour plus the scaled dominance terms
    typedef struct packed {
        t_rgb  c;
        t_chan alpha;
        t_dom  dg;
        t_dom  ds;
    } t_dom_beat;

    // source colour plus the working colour
    typedef struct packed {
        t_rgb  c;
        t_chan alpha;
        t_rgb  o;
    } t_work_beat;

endpackage

// ===== sv/ifcm_front.sv =====
// dominance measures and their gain products, two pipeline stages
module ifcm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ifcm_pkg::t_pix_in  i_pix,
    input  ifcm_pkg::t_gains   i_gains,
    output logic               o_valid,
    input  logic               i_ready,
    output ifcm_pkg::t_dom_beat o_beat
);

    typedef struct packed {
        ifcm_pkg::t_rgb  c;
        ifcm_pkg::t_chan alpha;
        ifcm_pkg::t_chan veg;
        ifcm_pkg::t_chan sky;
    } t_meas_beat;

    logic                r_va;
    logic                r_vb;
    t_meas_beat          r_a;
    t_meas_beat          n_a;
    ifcm_pkg::t_dom_beat r_b;
    ifcm_pkg::t_dom_beat n_b;
    logic                rdy_a;
    logic                rdy_b;
    ifcm_pkg::t_chan     max_rb;
    ifcm_pkg::t_chan     max_rg;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;
    assign o_beat  = r_b;

    always_comb begin
        n_a.c.r   = ifcm_pkg::t_chan'(i_pix.in_red);
        n_a.c.g   = ifcm_pkg::t_chan'(i_pix.in_green);
        n_a.c.b   = ifcm_pkg::t_chan'(i_pix.in_blue);
        n_a.alpha = ifcm_pkg::t_chan'(i_pix.in_alpha);
        max_rb    = (n_a.c.r > n_a.c.b) ? n_a.c.r : n_a.c.b;
        max_rg    = (n_a.c.r > n_a.c.g) ? n_a.c.r : n_a.c.g;
        n_a.veg   = (n_a.c.g > max_rb) ? n_a.c.g - max_rb : '0;
        n_a.sky   = (n_a.c.b > max_rg) ? n_a.c.b - max_rg : '0;
    end

    always_comb begin
        n_b.c     = r_a.c;
        n_b.alpha = r_a.alpha;
        n_b.dg    = ifcm_pkg::DOM_W'(r_a.veg) * ifcm_pkg::DOM_W'(i_gains.foliage);
        n_b.ds    = ifcm_pkg::DOM_W'(r_a.sky) * ifcm_pkg::DOM_W'(i_gains.sky);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a <= n_a;
        end
        if (rdy_b && r_va) begin
            r_b <= n_b;
        end
    end

endmodule

// ===== sv/ifcm_push.sv =====
// rounded push amounts and the saturating magenta and cyan shifts, two stages
module ifcm_push (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ifcm_pkg::t_dom_beat  i_beat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ifcm_pkg::t_work_beat o_beat
);

    typedef struct packed {
        ifcm_pkg::t_rgb  c;
        ifcm_pkg::t_chan alpha;
        ifcm_pkg::t_chan mag_red;
        ifcm_pkg::t_chan mag_blue;
        ifcm_pkg::t_chan mag_green;
        ifcm_pkg::t_chan cyan_green;
        ifcm_pkg::t_chan cyan_red;
    } t_push_beat;

    function automatic ifcm_pkg::t_chan push_round(
        input ifcm_pkg::t_dom         d,
        input logic [ifcm_pkg::K_W-1:0] k
    );
        logic [ifcm_pkg::PUSH_W-1:0] p;
        p = ifcm_pkg::PUSH_W'(d) * ifcm_pkg::PUSH_W'(k) + ifcm_pkg::PUSH_ROUND;
        return p[ifcm_pkg::PUSH_SHIFT +: ifcm_pkg::CHANNEL_BITS];
    endfunction

    function automatic ifcm_pkg::t_chan sat_add(
        input ifcm_pkg::t_chan a,
        input ifcm_pkg::t_chan b
    );
        logic [ifcm_pkg::CHANNEL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ifcm_pkg::CHANNEL_BITS] ? '1 : s[ifcm_pkg::CHANNEL_BITS-1:0];
    endfunction

    function automatic ifcm_pkg::t_chan sat_sub(
        input ifcm_pkg::t_chan a,
        input ifcm_pkg::t_chan b
    );
        return (a > b) ? a - b : '0;
    endfunction

    logic                 r_vc;
    logic                 r_vd;
    t_push_beat           r_c;
    t_push_beat           n_c;
    ifcm_pkg::t_work_beat r_d;
    ifcm_pkg::t_work_beat n_d;
    logic                 rdy_c;
    logic                 rdy_d;

    assign rdy_d   = !r_vd || i_ready;
    assign rdy_c   = !r_vc || rdy_d;
    assign o_ready = rdy_c;
    assign o_valid = r_vd;
    assign o_beat  = r_d;

    always_comb begin
        n_c.c          = i_beat.c;
        n_c.alpha      = i_beat.alpha;
        n_c.mag_red    = push_round(i_beat.dg, ifcm_pkg::K_MAG_RED);
        n_c.mag_blue   = push_round(i_beat.dg, ifcm_pkg::K_MAG_BLUE);
        n_c.mag_green  = push_round(i_beat.dg, ifcm_pkg::K_MAG_GREEN);
        n_c.cyan_green = push_round(i_beat.ds, ifcm_pkg::K_CYAN_GREEN);
        n_c.cyan_red   = push_round(i_beat.ds, ifcm_pkg::K_CYAN_RED);
    end

    // red and green swapped, then magenta push, then cyan push
    always_comb begin
        n_d.c     = r_c.c;
        n_d.alpha = r_c.alpha;
        n_d.o.r   = sat_sub(sat_add(r_c.c.g, r_c.mag_red), r_c.cyan_red);
        n_d.o.g   = sat_add(sat_sub(r_c.c.r, r_c.mag_green), r_c.cyan_green);
        n_d.o.b   = sat_add(r_c.c.b, r_c.mag_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_c) begin
                r_vc <= i_valid;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && i_valid) begin
            r_c <= n_c;
        end
        if (rdy_d && r_vc) begin
            r_d <= n_d;
        end
    end

endmodule

// ===== sv/ifcm_blend.sv =====
// one rounded q8 blend stage from the source colour toward the working colour
module ifcm_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ifcm_pkg::t_work_beat i_beat,
    input  ifcm_pkg::t_gain      i_weight,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ifcm_pkg::t_work_beat o_beat
);

    // a + (b - a) * t, rounded half up
    function automatic ifcm_pkg::t_chan lerp(
        input ifcm_pkg::t_chan a,
        input ifcm_pkg::t_chan b,
        input ifcm_pkg::t_gain t
    );
        logic signed [ifcm_pkg::DIFF_W-1:0]   diff;
        logic signed [ifcm_pkg::WEIGHT_W-1:0] wt;
        logic signed [ifcm_pkg::BLEND_W-1:0]  acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        wt   = $signed({1'b0, t});
        acc  = $signed(ifcm_pkg::BLEND_W'({a, {ifcm_pkg::BLEND_SHIFT{1'b0}}}))
             + $signed(ifcm_pkg::BLEND_W'(diff)) * $signed(ifcm_pkg::BLEND_W'(wt))
             + $signed(ifcm_pkg::BLEND_ROUND);
        return acc[ifcm_pkg::BLEND_SHIFT +: ifcm_pkg::CHANNEL_BITS];
    endfunction

    logic                 r_v;
    ifcm_pkg::t_work_beat r_beat;
    ifcm_pkg::t_work_beat n_beat;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_beat  = r_beat;

    always_comb begin
        n_beat.c     = i_beat.c;
        n_beat.alpha = i_beat.alpha;
        n_beat.o.r   = lerp(i_beat.c.r, i_beat.o.r, i_weight);
        n_beat.o.g   = lerp(i_beat.c.g, i_beat.o.g, i_weight);
        n_beat.o.b   = lerp(i_beat.c.b, i_beat.o.b, i_weight);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

// ===== sv/infrared_false_colour_map.sv =====
// top level of the infrared false-colour pixel map: config registers and pipeline
//
// channel   direction  handshake           payload
// pixel in  input      i_valid / o_ready   i_pix  (t_pix_in)
// pixel out output     o_valid / i_ready   o_pix  (t_pix_out)
// config    input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// one beat per clock sustained while i_ready stays high
// six register stages: dominance, gain product, push, shift, two blends
// each stage holds its beat while the next is full, bubbles close up under stall
// synchronous reset empties the pipeline and loads the default gains
module infrared_false_colour_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  ifcm_pkg::t_pix_in                    i_pix,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output ifcm_pkg::t_pix_out                   o_pix,
    input  logic                                 i_cfg_we,
    input  logic [ifcm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ifcm_pkg::GAIN_W-1:0]          i_cfg_data
);

    function automatic ifcm_pkg::t_gain gain_sat(input ifcm_pkg::t_gain g);
        return (g > ifcm_pkg::Q8_ONE) ? ifcm_pkg::Q8_ONE : g;
    endfunction

    ifcm_pkg::t_gain      r_effect_strength;
    ifcm_pkg::t_gain      r_foliage_gain;
    ifcm_pkg::t_gain      r_sky_gain;
    ifcm_pkg::t_gain      r_overall_mix;
    ifcm_pkg::t_gains     gains;

    logic                 front_valid;
    logic                 push_ready;
    ifcm_pkg::t_dom_beat  front_beat;
    logic                 push_valid;
    logic                 blend1_ready;
    ifcm_pkg::t_work_beat push_beat;
    logic                 blend1_valid;
    logic                 blend2_ready;
    ifcm_pkg::t_work_beat blend1_beat;
    ifcm_pkg::t_work_beat blend2_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_strength <= ifcm_pkg::RST_EFFECT_STRENGTH;
            r_foliage_gain    <= ifcm_pkg::RST_FOLIAGE_GAIN;
            r_sky_gain        <= ifcm_pkg::RST_SKY_GAIN;
            r_overall_mix     <= ifcm_pkg::RST_OVERALL_MIX;
        end else if (i_cfg_we) begin
            unique case (ifcm_pkg::t_cfg_idx'(i_cfg_idx))
                ifcm_pkg::CFG_EFFECT_STRENGTH: r_effect_strength <= i_cfg_data;
                ifcm_pkg::CFG_FOLIAGE_GAIN:    r_foliage_gain    <= i_cfg_data;
                ifcm_pkg::CFG_SKY_GAIN:        r_sky_gain        <= i_cfg_data;
                ifcm_pkg::CFG_OVERALL_MIX:     r_overall_mix     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // gains above one clamp to one
    always_comb begin
        gains.strength = gain_sat(r_effect_strength);
        gains.foliage  = gain_sat(r_foliage_gain);
        gains.sky      = gain_sat(r_sky_gain);
        gains.mix      = gain_sat(r_overall_mix);
    end

    ifcm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .i_gains (gains),
        .o_valid (front_valid),
        .i_ready (push_ready),
        .o_beat  (front_beat)
    );

    ifcm_push u_push (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (push_ready),
        .i_beat  (front_beat),
        .o_valid (push_valid),
        .i_ready (blend1_ready),
        .o_beat  (push_beat)
    );

    ifcm_blend u_blend_strength (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (push_valid),
        .o_ready  (blend1_ready),
        .i_beat   (push_beat),
        .i_weight (gains.strength),
        .o_valid  (blend1_valid),
        .i_ready  (blend2_ready),
        .o_beat   (blend1_beat)
    );

    ifcm_blend u_blend_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (blend1_valid),
        .o_ready  (blend2_ready),
        .i_beat   (blend1_beat),
        .i_weight (gains.mix),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_beat   (blend2_beat)
    );

    always_comb begin
        o_pix.out_red   = 8'(blend2_beat.o.r);
        o_pix.out_green = 8'(blend2_beat.o.g);
        o_pix.out_blue  = 8'(blend2_beat.o.b);
        o_pix.out_alpha = 8'(blend2_beat.alpha);
    end

endmodule
